FILE: sv/lfu_pkg.sv
package lfu_pkg;

  localparam int KEY_W   = 17;
  localparam int VAL_W   = 30;
  localparam int CNT_W   = 20;
  localparam int STAMP_W = 32;
  localparam int CAP_W   = 5;

  localparam logic [CAP_W-1:0]   CAP_RESET = 5'd16;
  localparam logic [CNT_W-1:0]   COUNT_MAX = '1;
  localparam logic [STAMP_W-1:0] CLOCK_MAX = '1;

  typedef struct packed {
    logic               tok;
    logic               hit;
    logic [VAL_W-1:0]   hit_value;
    logic               free;
    logic               vic;
    logic [CNT_W-1:0]   vic_count;
    logic [STAMP_W-1:0] vic_stamp;
  } carry_t;

  typedef struct packed {
    logic               we;
    logic               load;
    logic               wr;
    logic [KEY_W-1:0]   key;
    logic [VAL_W-1:0]   value;
    logic [STAMP_W-1:0] stamp;
  } upd_t;

endpackage

FILE: sv/lfu_req_if.sv
interface lfu_req_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [16:0] lookup_key;
  logic [29:0] write_value;

  modport source (output valid, func, lookup_key, write_value, input ready);
  modport sink (input valid, func, lookup_key, write_value, output ready);
endinterface

FILE: sv/lfu_rsp_if.sv
interface lfu_rsp_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [29:0] read_value;

  modport source (output valid, found, read_value, input ready);
  modport sink (input valid, found, read_value, output ready);
endinterface

FILE: sv/lfu_cell.sv
module lfu_cell #(
  parameter int IW  = 4,
  parameter int CW  = 5,
  parameter int IDX = 0
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [lfu_pkg::KEY_W-1:0] key,
  input  lfu_pkg::carry_t       c_in,
  input  logic [IW-1:0]         hit_idx_in,
  input  logic [IW-1:0]         free_idx_in,
  input  logic [IW-1:0]         vic_idx_in,
  input  logic [CW-1:0]         used_in,
  output lfu_pkg::carry_t       c_out,
  output logic [IW-1:0]         hit_idx_out,
  output logic [IW-1:0]         free_idx_out,
  output logic [IW-1:0]         vic_idx_out,
  output logic [CW-1:0]         used_out,
  input  lfu_pkg::upd_t         upd,
  input  logic                  sel
);
  import lfu_pkg::*;

  logic               valid;
  logic [KEY_W-1:0]   skey;
  logic [VAL_W-1:0]   value;
  logic [CNT_W-1:0]   count;
  logic [STAMP_W-1:0] stamp;

  carry_t        c_next;
  logic [IW-1:0] hit_idx_next, free_idx_next, vic_idx_next;
  logic [CW-1:0] used_next;

  always_comb begin
    c_next        = c_in;
    hit_idx_next  = hit_idx_in;
    free_idx_next = free_idx_in;
    vic_idx_next  = vic_idx_in;
    used_next     = used_in;
    if (valid) begin
      used_next = used_in + CW'(1);
      if (skey == key) begin
        c_next.hit       = 1'b1;
        c_next.hit_value = value;
        hit_idx_next     = IW'(IDX);
      end
      if (!c_in.vic || count < c_in.vic_count ||
          (count == c_in.vic_count && stamp < c_in.vic_stamp)) begin
        c_next.vic       = 1'b1;
        c_next.vic_count = count;
        c_next.vic_stamp = stamp;
        vic_idx_next     = IW'(IDX);
      end
    end else if (!c_in.free) begin
      c_next.free   = 1'b1;
      free_idx_next = IW'(IDX);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_out <= '0;
    end else begin
      c_out <= c_next;
    end
    hit_idx_out  <= hit_idx_next;
    free_idx_out <= free_idx_next;
    vic_idx_out  <= vic_idx_next;
    used_out     <= used_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (upd.we && sel) begin
      stamp <= upd.stamp;
      if (upd.load) begin
        valid <= 1'b1;
        skey  <= upd.key;
        value <= upd.value;
        count <= CNT_W'(1);
      end else begin
        if (count != COUNT_MAX) begin
          count <= count + CNT_W'(1);
        end
        if (upd.wr) begin
          value <= upd.value;
        end
      end
    end
  end

endmodule

FILE: sv/lfu_cache_table.sv
// LFU key-value cache with LRU tie-break.
// req channel (valid/ready): func (0 get, 1 put), lookup_key, write_value.
// rsp channel (valid/ready): found, read_value; one transaction per request.
// cfg_we/cfg_wdata write the capacity register (reset 16, clipped to ENTRIES).
// Entries live in a chain of ENTRIES cells. An accepted request launches a
// search token that moves one cell per cycle, gathering hit, first free slot,
// victim (lowest count, then oldest stamp) and the valid count.
// The response passes through the start register, the cell chain, the result
// registers and the output register. One request is in flight at a time: a new
// request is accepted only once the previous one has gone back to idle.
// A finished response sits in an output register; if rsp stalls, the write
// back of the next finished request waits until that register frees up.
// Reset (rst, synchronous) empties all entries, zeroes the access clock,
// restores capacity to 16 and drops any request in flight.
module lfu_cache_table #(
  parameter int ENTRIES = 16
) (
  input  logic            clk,
  input  logic            rst,
  lfu_req_if.sink         req,
  lfu_rsp_if.source       rsp,
  input  logic            cfg_we,
  input  logic [lfu_pkg::CAP_W-1:0] cfg_wdata
);
  import lfu_pkg::*;

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_DECIDE = 2'd2;

  logic [1:0]         state;
  logic               start;
  logic [CAP_W-1:0]   capacity;
  logic [STAMP_W-1:0] access_clock;
  logic               r_func;
  logic [KEY_W-1:0]   r_key;
  logic [VAL_W-1:0]   r_val;
  logic               out_valid;
  logic               out_found;
  logic [VAL_W-1:0]   out_value;

  carry_t        res;
  logic [IW-1:0] res_hit_idx, res_free_idx, res_vic_idx;
  logic [CW-1:0] res_used;

  carry_t        c     [ENTRIES+1];
  logic [IW-1:0] hidx  [ENTRIES+1];
  logic [IW-1:0] fidx  [ENTRIES+1];
  logic [IW-1:0] vidx  [ENTRIES+1];
  logic [CW-1:0] used  [ENTRIES+1];

  upd_t               upd;
  logic [IW-1:0]      upd_idx;
  logic               full;
  logic               fire;

  assign req.ready     = (state == S_IDLE);
  assign rsp.valid     = out_valid;
  assign rsp.found     = out_found;
  assign rsp.read_value = out_value;

  assign c[0]    = '{tok: start, hit: 1'b0, hit_value: '0, free: 1'b0,
                     vic: 1'b0, vic_count: '0, vic_stamp: '0};
  assign hidx[0] = '0;
  assign fidx[0] = '0;
  assign vidx[0] = '0;
  assign used[0] = '0;

  generate
    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
      lfu_cell #(.IW(IW), .CW(CW), .IDX(g)) u_cell (
        .clk          (clk),
        .rst          (rst),
        .key          (r_key),
        .c_in         (c[g]),
        .hit_idx_in   (hidx[g]),
        .free_idx_in  (fidx[g]),
        .vic_idx_in   (vidx[g]),
        .used_in      (used[g]),
        .c_out        (c[g+1]),
        .hit_idx_out  (hidx[g+1]),
        .free_idx_out (fidx[g+1]),
        .vic_idx_out  (vidx[g+1]),
        .used_out     (used[g+1]),
        .upd          (upd),
        .sel          (upd_idx == IW'(g))
      );
    end
  endgenerate

  assign full = (32'(res_used) >= 32'(capacity)) || (32'(res_used) == 32'(ENTRIES));
  assign fire = (state == S_DECIDE) && (!out_valid || rsp.ready);

  always_comb begin
    upd       = '0;
    upd.key   = r_key;
    upd.value = r_val;
    upd.stamp = access_clock;
    upd_idx   = res_hit_idx;
    if (fire) begin
      if (res.hit) begin
        upd.we = 1'b1;
        upd.wr = r_func;
      end else if (r_func && capacity != '0) begin
        upd.load = 1'b1;
        if (full) begin
          upd.we  = res.vic;
          upd_idx = res_vic_idx;
        end else begin
          upd.we  = res.free;
          upd_idx = res_free_idx;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      start        <= 1'b0;
      capacity     <= CAP_RESET;
      access_clock <= '0;
      out_valid    <= 1'b0;
    end else begin
      start <= 1'b0;
      if (cfg_we) begin
        capacity <= cfg_wdata;
      end
      if (out_valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            r_func <= req.func;
            r_key  <= req.lookup_key;
            r_val  <= req.write_value;
            start  <= 1'b1;
            state  <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (c[ENTRIES].tok) begin
            res          <= c[ENTRIES];
            res_hit_idx  <= hidx[ENTRIES];
            res_free_idx <= fidx[ENTRIES];
            res_vic_idx  <= vidx[ENTRIES];
            res_used     <= used[ENTRIES];
            state        <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (fire) begin
            out_valid <= 1'b1;
            out_found <= res.hit;
            out_value <= r_func ? r_val : (res.hit ? res.hit_value : '0);
            if (upd.we && access_clock != CLOCK_MAX) begin
              access_clock <= access_clock + STAMP_W'(1);
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
  import lfu_pkg::*;

  localparam int SLOTS = 16;
  localparam int IDLE_LIMIT = 20000;

  typedef enum logic {OP_GET = 1'b0, OP_PUT = 1'b1} op_e;

  typedef struct {
    op_e              op;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
    bit               has_exp;
    logic             exp_found;
    logic [VAL_W-1:0] exp_value;
  } row_t;

  typedef struct {
    logic             found;
    logic [VAL_W-1:0] value;
  } answer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CAP_W-1:0] cfg_wdata = '0;

  lfu_req_if req ();
  lfu_rsp_if rsp ();

  lfu_cache_table i_dut (
    .clk(clk), .rst(rst), .req(req.sink), .rsp(rsp.source),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  // cache shadow
  logic [CAP_W-1:0]   sh_cap;
  bit                 sh_valid [SLOTS];
  logic [KEY_W-1:0]   sh_key   [SLOTS];
  logic [VAL_W-1:0]   sh_val   [SLOTS];
  logic [CNT_W-1:0]   sh_cnt   [SLOTS];
  logic [STAMP_W-1:0] sh_stamp [SLOTS];
  logic [STAMP_W-1:0] sh_clock;

  answer_t answers_due [$];
  int errors = 0;
  int n_req = 0, n_rsp = 0, n_hit = 0, n_evict = 0;
  bit hold_rsp = 1'b0;

  initial begin
    forever #10 clk = ~clk;
  end

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("MISMATCH %s: got %0h expected %0h (response %0d)", what, got, want, n_rsp);
  endtask

  function automatic void touch_slot(int s);
    sh_stamp[s] = sh_clock;
    if (sh_clock != CLOCK_MAX) sh_clock++;
  endfunction

  function automatic answer_t cache_access(op_e op, logic [KEY_W-1:0] key,
                                           logic [VAL_W-1:0] value);
    answer_t a;
    int hit, free_s, vic, used, cap, s;
    hit = -1; free_s = -1; vic = -1; used = 0;
    cap = (sh_cap > SLOTS) ? SLOTS : sh_cap;
    for (int i = 0; i < SLOTS; i++) begin
      if (sh_valid[i]) begin
        used++;
        if (sh_key[i] == key) hit = i;
        if (vic < 0 || sh_cnt[i] < sh_cnt[vic] ||
            (sh_cnt[i] == sh_cnt[vic] && sh_stamp[i] < sh_stamp[vic])) vic = i;
      end else if (free_s < 0) begin
        free_s = i;
      end
    end
    a.found = (hit >= 0);
    a.value = '0;
    if (hit >= 0) begin
      n_hit++;
      if (op == OP_GET) a.value = sh_val[hit];
      else sh_val[hit] = value;
      if (sh_cnt[hit] != COUNT_MAX) sh_cnt[hit]++;
      touch_slot(hit);
    end
    if (op == OP_PUT) begin
      a.value = value;
      if (hit < 0 && cap != 0) begin
        s = (used >= cap) ? vic : free_s;
        if (used >= cap) n_evict++;
        if (s >= 0) begin
          sh_valid[s] = 1'b1;
          sh_key[s] = key;
          sh_val[s] = value;
          sh_cnt[s] = CNT_W'(1);
          touch_slot(s);
        end
      end
    end
    return a;
  endfunction

  task automatic idle_req();
    req.valid <= 1'b0;
    req.func <= 1'($urandom_range(0, 1));
    req.lookup_key <= KEY_W'($urandom);
    req.write_value <= VAL_W'($urandom);
  endtask

  task automatic gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return;
    idle_req();
    if (r < 95) repeat ($urandom_range(1, 4)) @(posedge clk);
    else repeat ($urandom_range(10, 60)) @(posedge clk);
  endtask

  task automatic send(op_e op, logic [KEY_W-1:0] key, logic [VAL_W-1:0] value);
    answer_t a;
    req.valid <= 1'b1;
    req.func <= op;
    req.lookup_key <= key;
    req.write_value <= value;
    do @(posedge clk); while (!req.ready);
    a = cache_access(op, key, value);
    answers_due.push_back(a);
    n_req++;
  endtask

  task automatic drain();
    int n;
    n = 0;
    idle_req();
    while (answers_due.size() != 0 && n < 100000) begin
      @(posedge clk);
      n++;
    end
    repeat (40) @(posedge clk);
  endtask

  task automatic set_capacity(logic [CAP_W-1:0] c);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= c;
    @(posedge clk);
    cfg_we <= 1'b0;
    sh_cap = c;
  endtask

  // response checker
  initial begin
    answer_t a;
    rsp.ready = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_rsp) rsp.ready <= 1'b0;
      else rsp.ready <= ($urandom_range(0, 9) < 7);
      @(posedge clk);
      if (rsp.valid && rsp.ready) begin
        n_rsp++;
        if (answers_due.size() == 0) begin
          report("unexpected response", 32'd1, 32'd0);
        end else begin
          a = answers_due.pop_front();
          if (rsp.found !== a.found) report("found", 32'(rsp.found), 32'(a.found));
          if (rsp.read_value !== a.value)
            report("read_value", 32'(rsp.read_value), 32'(a.value));
        end
      end
    end
  end

  // watchdog
  initial begin
    int idle;
    idle = 0;
    forever begin
      @(posedge clk);
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || cfg_we) idle = 0;
      else idle++;
      if (idle >= IDLE_LIMIT) begin
        $display("Timeout: no transaction for %0d cycles", IDLE_LIMIT);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  task automatic check_row(row_t r);
    answer_t a;
    send(r.op, r.key, r.value);
    if (r.has_exp) begin
      a = answers_due[$];
      if (a.found !== r.exp_found) report("directed found", 32'(a.found), 32'(r.exp_found));
      if (a.value !== r.exp_value)
        report("directed read_value", 32'(a.value), 32'(r.exp_value));
    end
    gap();
  endtask

  initial begin
    row_t dir [$];
    int pool;
    logic [KEY_W-1:0] keys [8];
    req.valid = 1'b0;
    req.func = 1'b0;
    req.lookup_key = '0;
    req.write_value = '0;
    sh_cap = CAP_RESET;
    sh_clock = '0;
    for (int i = 0; i < SLOTS; i++) begin
      sh_valid[i] = 0; sh_key[i] = '0; sh_val[i] = '0; sh_cnt[i] = '0; sh_stamp[i] = '0;
    end
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    dir.push_back('{OP_GET, 17'h1FFFF, 30'h3FFFFFFF, 1, 1'b0, 30'h0});
    dir.push_back('{OP_PUT, 17'h0, 30'h0, 1, 1'b0, 30'h0});
    dir.push_back('{OP_PUT, 17'h1FFFF, 30'h3FFFFFFF, 1, 1'b0, 30'h3FFFFFFF});
    dir.push_back('{OP_GET, 17'h1FFFF, 30'h0, 1, 1'b1, 30'h3FFFFFFF});
    dir.push_back('{OP_GET, 17'h0, 30'h3FFFFFFF, 1, 1'b1, 30'h0});
    dir.push_back('{OP_PUT, 17'h0, 30'h2AAAAAAA, 1, 1'b1, 30'h2AAAAAAA});
    dir.push_back('{OP_GET, 17'h15555, 30'h0, 1, 1'b0, 30'h0});
    for (int k = 1; k <= 16; k++)
      dir.push_back('{OP_PUT, KEY_W'(k * 7), VAL_W'(k), 0, 1'b0, 30'h0});
    dir.push_back('{OP_GET, 17'h0, 30'h0, 0, 1'b0, 30'h0});
    foreach (dir[i]) check_row(dir[i]);

    set_capacity(5'd0);
    check_row('{OP_PUT, 17'h0ABCD, 30'h1234, 1, 1'b0, 30'h1234});
    check_row('{OP_GET, 17'h0ABCD, 30'h0, 1, 1'b0, 30'h0});
    check_row('{OP_GET, 17'h1FFFF, 30'h0, 0, 1'b0, 30'h0});
    set_capacity(5'd31);
    check_row('{OP_PUT, 17'h0ABCD, 30'h1234, 0, 1'b0, 30'h0});

    // long receiver stall while requests keep coming
    hold_rsp = 1'b1;
    fork
      begin
        repeat (400) @(posedge clk);
        hold_rsp = 1'b0;
      end
      for (int i = 0; i < 6; i++) begin
        send(op_e'($urandom_range(0, 1)), KEY_W'($urandom_range(0, 40)), VAL_W'($urandom));
      end
    join

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_capacity(5'd3);
        1: set_capacity(5'd16);
        2: set_capacity(5'd1);
        3: set_capacity(5'd8);
        4: set_capacity(5'd0);
        default: set_capacity(5'd17);
      endcase
      pool = (ph % 2) ? 24 : 10;
      for (int i = 0; i < 8; i++) keys[i] = KEY_W'($urandom_range(0, pool));
      for (int i = 0; i < 300; i++) begin
        int r;
        logic [KEY_W-1:0] k;
        r = $urandom_range(0, 99);
        if (r < 50) k = keys[$urandom_range(0, 7)];
        else if (r < 90) k = KEY_W'($urandom_range(0, pool));
        else k = KEY_W'($urandom);
        send(op_e'($urandom_range(0, 1)), k, VAL_W'($urandom));
        gap();
      end
    end

    drain();
    $display("Covered %0d requests: %0d hits, %0d evictions, capacities 0..31 incl. clipping",
             n_req, n_hit, n_evict);
    $display("Responses checked: %0d, leftover expectations: %0d", n_rsp, answers_due.size());
    if (errors == 0 && answers_due.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
